### sv/gbqg_pkg.sv
// Shared constants, codes and types of the grid boundary quad generator.
`default_nettype none

package gbqg_pkg;

   // Fixed field widths of the external interface.
   localparam int IDX_W      = 30;
   localparam int CFG_W      = 11;
   localparam int FACE_W     = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Default bound on the node count of one axis.
   localparam int MAX_NODES_DEFAULT = 1024;

   // Queue depths between the parts of the block.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_NODES_X = 2'd0;
   localparam logic [1:0] REG_NODES_Y = 2'd1;
   localparam logic [1:0] REG_NODES_Z = 2'd2;

   // Face codes as carried on the result port.
   localparam logic [FACE_W-1:0] FACE_ZMIN  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_ZMAX  = 3'd1;
   localparam logic [FACE_W-1:0] FACE_XMIN  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_XMAX  = 3'd3;
   localparam logic [FACE_W-1:0] FACE_YMIN  = 3'd4;
   localparam logic [FACE_W-1:0] FACE_YMAX  = 3'd5;
   localparam logic [FACE_W-1:0] FACE_PLANE = 3'd6;

   // Step in linear index from the first corner towards a neighbour:
   // one along x, one row (nodes_x) along y, one plane (nodes_x*nodes_y) along z.
   typedef enum logic [1:0] {
      STRIDE_ONE,
      STRIDE_ROW,
      STRIDE_PLANE
   } stride_sel_type;

   // Control part of a classified quad travelling from front to back.
   typedef struct packed {
      stride_sel_type          stride_b;
      stride_sel_type          stride_d;
      logic [FACE_W-1:0]       face_id;
      logic                    last;
   } quad_ctl_type;

   localparam int CTL_W = $bits(quad_ctl_type);

endpackage

`default_nettype wire

### sv/gbqg_fifo.sv
// Small first-in first-out queue of fixed-width words.
`default_nettype none

module gbqg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == CNTW'(DEPTH));
   assign empty = (count_ff == '0);

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   a_count_up : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fill count did not rise on a lone write");

   a_count_down : assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("fill count did not fall on a lone read");

endmodule

`default_nettype wire

### sv/gbqg_front.sv
// Sweep sequencer: takes request words, walks the face counters and classifies each quad.
`default_nettype none

module gbqg_front #(
   parameter int MAX_NODES = gbqg_pkg::MAX_NODES_DEFAULT,
   localparam int CW = $clog2(MAX_NODES),
   localparam int NW = $clog2(MAX_NODES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire logic                 start,
   input  wire logic [NW-1:0]        nodes_x,
   input  wire logic [NW-1:0]        nodes_y,
   input  wire logic [NW-1:0]        nodes_z,
   output logic                      quad_valid,
   output logic      [CW-1:0]        base_x,
   output logic      [CW-1:0]        base_y,
   output logic      [CW-1:0]        base_z,
   output gbqg_pkg::quad_ctl_type    quad_ctl
);

   import gbqg_pkg::*;

   logic                active_ff, active_in;
   logic [FACE_W-1:0]   face_ff, face_in;
   logic [CW-1:0]       outer_ff, outer_in;
   logic [CW-1:0]       inner_ff, inner_in;

   logic                is3d;
   logic                active_cur;
   logic [FACE_W-1:0]   face_cur, face_sel;
   logic [CW-1:0]       outer_cur, inner_cur;
   logic [NW-1:0]       xm1, ym1, zm1;
   logic [NW-1:0]       lim_outer, lim_inner;
   logic                empty_plane, emit;
   logic [NW:0]         inner_inc, outer_inc;
   logic                end_inner, end_outer, last;
   logic [FACE_W-1:0]   face_next;
   logic [CW-1:0]       outer_next, inner_next;

   always_comb begin
      xm1  = nodes_x - 1'b1;
      ym1  = nodes_y - 1'b1;
      zm1  = nodes_z - 1'b1;
      is3d = (nodes_x > NW'(1)) && (nodes_y > NW'(1)) && (nodes_z > NW'(1));

      // A start word restarts the sweep at its first quad on the same word.
      active_cur = start | active_ff;
      face_cur   = start ? (is3d ? FACE_ZMIN : FACE_PLANE) : face_ff;
      outer_cur  = start ? '0 : outer_ff;
      inner_cur  = start ? '0 : inner_ff;

      if (!is3d) begin
         face_sel = FACE_PLANE;
      end else if (face_cur > FACE_YMAX) begin
         face_sel = FACE_YMAX;
      end else begin
         face_sel = face_cur;
      end

      lim_outer = zm1;
      lim_inner = xm1;
      base_x    = inner_cur;
      base_y    = outer_cur;
      base_z    = '0;
      quad_ctl.stride_b = STRIDE_ONE;
      quad_ctl.stride_d = STRIDE_ROW;
      unique case (face_sel)
         FACE_ZMIN: begin
            lim_outer = ym1;  lim_inner = xm1;
            base_x = inner_cur;  base_y = outer_cur;  base_z = '0;
            quad_ctl.stride_b = STRIDE_ROW;  quad_ctl.stride_d = STRIDE_ONE;
         end
         FACE_ZMAX: begin
            lim_outer = ym1;  lim_inner = xm1;
            base_x = inner_cur;  base_y = outer_cur;  base_z = CW'(zm1);
            quad_ctl.stride_b = STRIDE_ONE;  quad_ctl.stride_d = STRIDE_ROW;
         end
         FACE_XMIN: begin
            lim_outer = zm1;  lim_inner = ym1;
            base_x = '0;  base_y = inner_cur;  base_z = outer_cur;
            quad_ctl.stride_b = STRIDE_PLANE;  quad_ctl.stride_d = STRIDE_ROW;
         end
         FACE_XMAX: begin
            lim_outer = zm1;  lim_inner = ym1;
            base_x = CW'(xm1);  base_y = inner_cur;  base_z = outer_cur;
            quad_ctl.stride_b = STRIDE_ROW;  quad_ctl.stride_d = STRIDE_PLANE;
         end
         FACE_YMIN: begin
            lim_outer = zm1;  lim_inner = xm1;
            base_x = inner_cur;  base_y = '0;  base_z = outer_cur;
            quad_ctl.stride_b = STRIDE_ONE;  quad_ctl.stride_d = STRIDE_PLANE;
         end
         FACE_YMAX: begin
            lim_outer = zm1;  lim_inner = xm1;
            base_x = inner_cur;  base_y = CW'(ym1);  base_z = outer_cur;
            quad_ctl.stride_b = STRIDE_PLANE;  quad_ctl.stride_d = STRIDE_ONE;
         end
         default: begin
            // Single plane: the first flat axis in the order z, y, x picks it.
            if (nodes_z == NW'(1)) begin
               lim_outer = ym1;  lim_inner = xm1;
               base_x = inner_cur;  base_y = outer_cur;  base_z = '0;
               quad_ctl.stride_b = STRIDE_ONE;  quad_ctl.stride_d = STRIDE_ROW;
            end else if (nodes_y == NW'(1)) begin
               lim_outer = zm1;  lim_inner = xm1;
               base_x = inner_cur;  base_y = '0;  base_z = outer_cur;
               quad_ctl.stride_b = STRIDE_ONE;  quad_ctl.stride_d = STRIDE_PLANE;
            end else begin
               lim_outer = zm1;  lim_inner = ym1;
               base_x = '0;  base_y = inner_cur;  base_z = outer_cur;
               quad_ctl.stride_b = STRIDE_ROW;  quad_ctl.stride_d = STRIDE_PLANE;
            end
         end
      endcase

      empty_plane = (lim_outer == '0) || (lim_inner == '0);
      emit        = active_cur && !empty_plane;

      // A counter already past a shrunken bound also ends its loop.
      inner_inc = (NW + 1)'(inner_cur) + 1'b1;
      outer_inc = (NW + 1)'(outer_cur) + 1'b1;
      end_inner = (inner_inc >= (NW + 1)'(lim_inner));
      end_outer = (outer_inc >= (NW + 1)'(lim_outer));
      last      = (face_sel >= FACE_YMAX) && end_outer && end_inner;

      quad_ctl.face_id = face_sel;
      quad_ctl.last    = last;

      face_next  = face_sel;
      outer_next = outer_cur;
      inner_next = CW'(inner_inc);
      if (end_inner) begin
         inner_next = '0;
         if (end_outer) begin
            outer_next = '0;
            face_next  = face_sel + 1'b1;
         end else begin
            outer_next = CW'(outer_inc);
         end
      end

      active_in = active_cur && !empty_plane && !last;
      face_in   = emit ? face_next  : face_cur;
      outer_in  = emit ? outer_next : outer_cur;
      inner_in  = emit ? inner_next : inner_cur;

      quad_valid = item_valid && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         face_ff   <= '0;
         outer_ff  <= '0;
         inner_ff  <= '0;
      end else if (item_valid) begin
         active_ff <= active_in;
         face_ff   <= face_in;
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
      end
   end

endmodule

`default_nettype wire

### sv/gbqg_back.sv
// Index pipeline: turns a classified quad into four linear vertex indices.
`default_nettype none

module gbqg_back #(
   parameter int MAX_NODES = gbqg_pkg::MAX_NODES_DEFAULT,
   localparam int CW = $clog2(MAX_NODES),
   localparam int NW = $clog2(MAX_NODES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire logic [CW-1:0]                 head_x,
   input  wire logic [CW-1:0]                 head_y,
   input  wire logic [CW-1:0]                 head_z,
   input  gbqg_pkg::quad_ctl_type             head_ctl,
   output logic                               head_pop,
   input  wire logic [NW-1:0]                 nodes_x,
   input  wire logic [NW-1:0]                 nodes_y,
   input  wire logic                          out_full,
   output logic                               out_push,
   output logic      [gbqg_pkg::IDX_W-1:0]    corner_a,
   output logic      [gbqg_pkg::IDX_W-1:0]    corner_b,
   output logic      [gbqg_pkg::IDX_W-1:0]    corner_c,
   output logic      [gbqg_pkg::IDX_W-1:0]    corner_d,
   output logic      [gbqg_pkg::FACE_W-1:0]   face_id,
   output logic                               last
);

   import gbqg_pkg::*;

   function automatic logic [IDX_W-1:0] stride_value(input stride_sel_type sel,
                                                     input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] plane);
      logic [IDX_W-1:0] v;
      begin
         unique case (sel)
            STRIDE_ONE:   v = IDX_W'(1);
            STRIDE_ROW:   v = row;
            STRIDE_PLANE: v = plane;
            default:      v = IDX_W'(1);
         endcase
         return v;
      end
   endfunction

   logic                 en;

   // First stage: row product and plane size.
   logic                 a_valid_ff;
   logic [CW-1:0]        a_x_ff, a_z_ff;
   logic [CW+NW-1:0]     a_yx_ff, a_yx_in;
   logic [2*NW-1:0]      a_xy_ff, a_xy_in;
   quad_ctl_type         a_ctl_ff;

   // Second stage: first corner and the two neighbour strides.
   logic                 b_valid_ff;
   logic [CW+2*NW-1:0]   b_zxy;
   logic [IDX_W-1:0]     b_base_ff, b_base_in;
   logic [IDX_W-1:0]     b_sb_ff, b_sb_in;
   logic [IDX_W-1:0]     b_sd_ff, b_sd_in;
   quad_ctl_type         b_ctl_ff;

   always_comb begin
      en       = !out_full;
      head_pop = en && head_valid;
      out_push = en && b_valid_ff;

      a_yx_in = head_y * nodes_x;
      a_xy_in = nodes_x * nodes_y;

      b_zxy     = a_z_ff * a_xy_ff;
      b_base_in = IDX_W'(a_x_ff) + IDX_W'(a_yx_ff) + IDX_W'(b_zxy);
      b_sb_in   = stride_value(a_ctl_ff.stride_b, IDX_W'(nodes_x), IDX_W'(a_xy_ff));
      b_sd_in   = stride_value(a_ctl_ff.stride_d, IDX_W'(nodes_x), IDX_W'(a_xy_ff));

      corner_a = b_base_ff;
      corner_b = b_base_ff + b_sb_ff;
      corner_c = b_base_ff + b_sb_ff + b_sd_ff;
      corner_d = b_base_ff + b_sd_ff;
      face_id  = b_ctl_ff.face_id;
      last     = b_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= head_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= head_x;
         a_z_ff    <= head_z;
         a_yx_ff   <= a_yx_in;
         a_xy_ff   <= a_xy_in;
         a_ctl_ff  <= head_ctl;
         b_base_ff <= b_base_in;
         b_sb_ff   <= b_sb_in;
         b_sd_ff   <= b_sd_in;
         b_ctl_ff  <= a_ctl_ff;
      end
   end

endmodule

`default_nettype wire

### sv/grid_boundary_quad_generator_core.sv
// The result word for an accepted request word passes through the middle queue, the back
// stages and the result queue before it shows on the result ports.
// Throughput: one request word and one result word per cycle, sustained while the consumer pops.
// A request word that causes no result (idle advance, empty plane) leaves nothing behind.
// Reset is synchronous and active high: the sweep goes idle, all queues empty and every
// node count register returns to one.
// Top level of the grid boundary quad generator: register file, sweep front, index back.
`default_nettype none

module grid_boundary_quad_generator_core #(
   parameter int MAX_NODES = gbqg_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic                               req_start_req,

   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic      [gbqg_pkg::IDX_W-1:0]         rsp_corner_a,
   output logic      [gbqg_pkg::IDX_W-1:0]         rsp_corner_b,
   output logic      [gbqg_pkg::IDX_W-1:0]         rsp_corner_c,
   output logic      [gbqg_pkg::IDX_W-1:0]         rsp_corner_d,
   output logic      [gbqg_pkg::FACE_W-1:0]        rsp_face_id,
   output logic                                    rsp_last,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [gbqg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [gbqg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [gbqg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready
);

   import gbqg_pkg::*;

   localparam int CW    = $clog2(MAX_NODES);
   localparam int NW    = $clog2(MAX_NODES + 1);
   localparam int EW    = (CFG_W > NW) ? CFG_W : NW;
   localparam int MID_W = 3 * CW + CTL_W;
   localparam int OUT_W = 4 * IDX_W + FACE_W + 1;

   // Count register as written, taken to the count that the sweep works with:
   // zero reads as one node and anything above the bound as the bound.
   function automatic logic [NW-1:0] eff_count(input logic [CFG_W-1:0] v);
      logic [EW-1:0] w;
      logic [NW-1:0] r;
      begin
         w = EW'(v);
         if (v == '0) begin
            r = NW'(1);
         end else if (w > EW'(MAX_NODES)) begin
            r = NW'(MAX_NODES);
         end else begin
            r = NW'(w);
         end
         return r;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. Every write completes in its access cycle,
   // so pready is tied high. Words are at byte addresses 0, 4 and 8; a
   // write to any other register slot is dropped and reads back as zero.
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] nodes_x_ff, nodes_y_ff, nodes_z_ff;
   logic [1:0]       csr_index;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_x_ff <= CFG_W'(1);
         nodes_y_ff <= CFG_W'(1);
         nodes_z_ff <= CFG_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_NODES_X: nodes_x_ff <= csr_pwdata[CFG_W-1:0];
            REG_NODES_Y: nodes_y_ff <= csr_pwdata[CFG_W-1:0];
            REG_NODES_Z: nodes_z_ff <= csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_NODES_X: csr_prdata = CSR_DATA_W'(nodes_x_ff);
         REG_NODES_Y: csr_prdata = CSR_DATA_W'(nodes_y_ff);
         REG_NODES_Z: csr_prdata = CSR_DATA_W'(nodes_z_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Effective counts feed both halves. The user must change configuration only while
   // no result is outstanding; the block does not enforce it and the back half uses them live.
   logic [NW-1:0] eff_x, eff_y, eff_z;

   assign eff_x = eff_count(nodes_x_ff);
   assign eff_y = eff_count(nodes_y_ff);
   assign eff_z = eff_count(nodes_z_ff);

   // ---------------------------------------------------------------------
   // Front half. It holds the sweep position and, for every request word,
   // decides in the same cycle whether a quad comes out, which face it is
   // on, where its first corner lies and in which directions the other
   // corners sit. Request words are taken whenever the middle queue has room.
   // ---------------------------------------------------------------------
   logic          mid_full, mid_empty, mid_pop;
   logic          item_valid;
   logic          quad_valid;
   logic [CW-1:0] quad_x, quad_y, quad_z;
   quad_ctl_type  quad_ctl;

   assign req_full   = mid_full;
   assign item_valid = req_push && !mid_full;

   gbqg_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .start      (req_start_req),
      .nodes_x    (eff_x),
      .nodes_y    (eff_y),
      .nodes_z    (eff_z),
      .quad_valid (quad_valid),
      .base_x     (quad_x),
      .base_y     (quad_y),
      .base_z     (quad_z),
      .quad_ctl   (quad_ctl)
   );

   // Middle queue: classified quads wait here so that a stalled consumer
   // does not stop the front from taking further request words.
   logic [MID_W-1:0] mid_rdata;
   logic [CW-1:0]    head_x, head_y, head_z;
   quad_ctl_type     head_ctl;

   gbqg_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (quad_valid),
      .wdata ({quad_x, quad_y, quad_z, quad_ctl}),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .full  (mid_full),
      .empty (mid_empty)
   );

   assign {head_x, head_y, head_z, head_ctl} = mid_rdata;

   // ---------------------------------------------------------------------
   // Back half. Two registered stages: the first forms y*nodes_x and the
   // plane size nodes_x*nodes_y, the second adds z times the plane size to
   // give the first corner. The other three corners are that index plus
   // one or both neighbour strides, formed on the way into the result queue.
   // The whole pipeline holds while the result queue is full.
   // ---------------------------------------------------------------------
   logic                 out_full, out_push;
   logic [IDX_W-1:0]     back_a, back_b, back_c, back_d;
   logic [FACE_W-1:0]    back_face;
   logic                 back_last;

   gbqg_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!mid_empty),
      .head_x     (head_x),
      .head_y     (head_y),
      .head_z     (head_z),
      .head_ctl   (head_ctl),
      .head_pop   (mid_pop),
      .nodes_x    (eff_x),
      .nodes_y    (eff_y),
      .out_full   (out_full),
      .out_push   (out_push),
      .corner_a   (back_a),
      .corner_b   (back_b),
      .corner_c   (back_c),
      .corner_d   (back_d),
      .face_id    (back_face),
      .last       (back_last)
   );

   // Result queue: the oldest finished quad is shown while rsp_empty is low.
   logic [OUT_W-1:0] out_rdata;
   logic             out_pop;

   assign out_pop = rsp_pop && !rsp_empty;

   gbqg_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata ({back_a, back_b, back_c, back_d, back_face, back_last}),
      .pop   (out_pop),
      .rdata (out_rdata),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign {rsp_corner_a, rsp_corner_b, rsp_corner_c, rsp_corner_d,
           rsp_face_id, rsp_last} = out_rdata;

endmodule

`default_nettype wire

### tb/sv/grid_boundary_quad_generator_core_test.sv
// Self-checking testbench for the grid boundary quad generator: directed and random sweeps.
module grid_boundary_quad_generator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gbqg_pkg::*;

   // The block is built with its default bound on the node count of one axis.
   localparam int MAX_NODES = MAX_NODES_DEFAULT;

   // A request word that makes no quad gives no sign of completion, so the bench
   // waits on for QUIET_CYCLES after the last quad before it goes on.
   localparam int QUIET_CYCLES = 8;
   localparam int RANDOM_WORDS = 1575;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LINES = 20;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [IDX_W-1:0]  corner_a;
      logic [IDX_W-1:0]  corner_b;
      logic [IDX_W-1:0]  corner_c;
      logic [IDX_W-1:0]  corner_d;
      logic [FACE_W-1:0] face_id;
      logic              last;
   } quad_word_type;

   // The scoreboard keeps its own copy of the node count registers and of the sweep
   // position. Each accepted request word is run through the sweep at once, and any
   // quad it makes is queued until the block hands the matching result word over.
   class quad_scoreboard;
      logic [CFG_W-1:0]  node_count [3];
      bit                sweep_on;
      logic [FACE_W-1:0] face_ctr;
      int unsigned       outer_ctr;
      int unsigned       inner_ctr;
      quad_word_type     quads_due [$];
      int unsigned       mismatches;
      int unsigned       quads_checked;

      function new();
         node_count    = '{11'd1, 11'd1, 11'd1};
         sweep_on      = 1'b0;
         face_ctr      = FACE_ZMIN;
         outer_ctr     = 0;
         inner_ctr     = 0;
         mismatches    = 0;
         quads_checked = 0;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= REPORT_LINES)
            $display("ERROR at %0t ns: %s", $time, what);
      endtask

      // A count of zero behaves as one and a count above the bound as the bound.
      function int unsigned usable(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_NODES) return MAX_NODES;
         return v;
      endfunction

      function logic [IDX_W-1:0] linear(int unsigned x, int unsigned y, int unsigned z,
                                        int unsigned nx, int unsigned ny);
         longint unsigned lx, ly, lz, v;
         lx = x;
         ly = y;
         lz = z;
         v  = lx + ly * nx + lz * nx * ny;
         return v[IDX_W-1:0];
      endfunction

      // Returns 1 when the request word makes a quad.
      function bit note_request(bit start);
         int unsigned       nx, ny, nz, lo_lim, in_lim, o, i;
         int unsigned       px [4];
         int unsigned       py [4];
         int unsigned       pz [4];
         logic [FACE_W-1:0] f;
         bit                solid, end_inner, end_outer, is_last;
         quad_word_type     q;
         nx    = usable(node_count[REG_NODES_X]);
         ny    = usable(node_count[REG_NODES_Y]);
         nz    = usable(node_count[REG_NODES_Z]);
         solid = (nx > 1) && (ny > 1) && (nz > 1);
         if (start) begin
            sweep_on  = 1'b1;
            face_ctr  = solid ? FACE_ZMIN : FACE_PLANE;
            outer_ctr = 0;
            inner_ctr = 0;
         end
         if (!sweep_on) return 1'b0;

         // Counts are live: a sweep carries on across a change of grid shape.
         if (!solid) f = FACE_PLANE;
         else if (face_ctr > FACE_YMAX) f = FACE_YMAX;
         else f = face_ctr;

         case (f)
            FACE_ZMIN, FACE_ZMAX: begin
               lo_lim = ny - 1;
               in_lim = nx - 1;
            end
            FACE_XMIN, FACE_XMAX: begin
               lo_lim = nz - 1;
               in_lim = ny - 1;
            end
            FACE_YMIN, FACE_YMAX: begin
               lo_lim = nz - 1;
               in_lim = nx - 1;
            end
            default: begin
               if (nz == 1) begin
                  lo_lim = ny - 1;
                  in_lim = nx - 1;
               end else if (ny == 1) begin
                  lo_lim = nz - 1;
                  in_lim = nx - 1;
               end else begin
                  lo_lim = nz - 1;
                  in_lim = ny - 1;
               end
            end
         endcase
         // A plane with no quads ends the sweep silently.
         if (lo_lim == 0 || in_lim == 0) begin
            sweep_on = 1'b0;
            return 1'b0;
         end

         o = outer_ctr;
         i = inner_ctr;
         case (f)
            FACE_ZMIN: begin
               px = '{i, i, i + 1, i + 1};
               py = '{o, o + 1, o + 1, o};
               pz = '{0, 0, 0, 0};
            end
            FACE_ZMAX: begin
               px = '{i, i + 1, i + 1, i};
               py = '{o, o, o + 1, o + 1};
               pz = '{nz - 1, nz - 1, nz - 1, nz - 1};
            end
            FACE_XMIN: begin
               px = '{0, 0, 0, 0};
               py = '{i, i, i + 1, i + 1};
               pz = '{o, o + 1, o + 1, o};
            end
            FACE_XMAX: begin
               px = '{nx - 1, nx - 1, nx - 1, nx - 1};
               py = '{i, i + 1, i + 1, i};
               pz = '{o, o, o + 1, o + 1};
            end
            FACE_YMIN: begin
               px = '{i, i + 1, i + 1, i};
               py = '{0, 0, 0, 0};
               pz = '{o, o, o + 1, o + 1};
            end
            FACE_YMAX: begin
               px = '{i, i, i + 1, i + 1};
               py = '{ny - 1, ny - 1, ny - 1, ny - 1};
               pz = '{o, o + 1, o + 1, o};
            end
            default: begin
               if (nz == 1) begin
                  px = '{i, i + 1, i + 1, i};
                  py = '{o, o, o + 1, o + 1};
                  pz = '{0, 0, 0, 0};
               end else if (ny == 1) begin
                  px = '{i, i + 1, i + 1, i};
                  py = '{0, 0, 0, 0};
                  pz = '{o, o, o + 1, o + 1};
               end else begin
                  px = '{0, 0, 0, 0};
                  py = '{i, i + 1, i + 1, i};
                  pz = '{o, o, o + 1, o + 1};
               end
            end
         endcase

         q.corner_a = linear(px[0], py[0], pz[0], nx, ny);
         q.corner_b = linear(px[1], py[1], pz[1], nx, ny);
         q.corner_c = linear(px[2], py[2], pz[2], nx, ny);
         q.corner_d = linear(px[3], py[3], pz[3], nx, ny);

         // A counter beyond a shrunken bound counts as the end of its loop.
         end_inner = (i + 1 >= in_lim);
         end_outer = (o + 1 >= lo_lim);
         is_last   = (f >= FACE_YMAX) && end_outer && end_inner;
         q.face_id = f;
         q.last    = is_last;
         quads_due = {quads_due, q};

         if (end_inner) begin
            inner_ctr = 0;
            if (end_outer) begin
               outer_ctr = 0;
               f = f + 1'b1;
            end else begin
               outer_ctr++;
            end
         end else begin
            inner_ctr++;
         end
         face_ctr = f;
         if (is_last) sweep_on = 1'b0;
         return 1'b1;
      endfunction

      task check_word(quad_word_type got);
         quad_word_type want;
         if (quads_due.size() == 0) begin
            report($sformatf("unexpected quad a=%0d b=%0d c=%0d d=%0d face=%0d last=%0d",
                             got.corner_a, got.corner_b, got.corner_c, got.corner_d,
                             got.face_id, got.last));
            return;
         end
         want = quads_due.pop_front();
         quads_checked++;
         if (got.corner_a !== want.corner_a)
            report($sformatf("quad %0d corner_a %0d, expected %0d",
                             quads_checked, got.corner_a, want.corner_a));
         if (got.corner_b !== want.corner_b)
            report($sformatf("quad %0d corner_b %0d, expected %0d",
                             quads_checked, got.corner_b, want.corner_b));
         if (got.corner_c !== want.corner_c)
            report($sformatf("quad %0d corner_c %0d, expected %0d",
                             quads_checked, got.corner_c, want.corner_c));
         if (got.corner_d !== want.corner_d)
            report($sformatf("quad %0d corner_d %0d, expected %0d",
                             quads_checked, got.corner_d, want.corner_d));
         if (got.face_id !== want.face_id)
            report($sformatf("quad %0d face_id %0d, expected %0d",
                             quads_checked, got.face_id, want.face_id));
         if (got.last !== want.last)
            report($sformatf("quad %0d last %0d, expected %0d",
                             quads_checked, got.last, want.last));
      endtask
   endclass

   // Every input of the block starts at a known value; reset is held from time zero.
   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_push      = 1'b0;
   logic                    req_start_req = 1'b0;
   logic                    rsp_pop       = 1'b0;
   logic                    csr_psel      = 1'b0;
   logic                    csr_penable   = 1'b0;
   logic                    csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr     = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata    = '0;

   logic                    req_full;
   logic                    rsp_empty;
   logic [IDX_W-1:0]        rsp_corner_a;
   logic [IDX_W-1:0]        rsp_corner_b;
   logic [IDX_W-1:0]        rsp_corner_c;
   logic [IDX_W-1:0]        rsp_corner_d;
   logic [FACE_W-1:0]       rsp_face_id;
   logic                    rsp_last;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int                      idle_pct      = 0;
   int                      stall_pct     = 0;
   int unsigned             cycle_count   = 0;
   int unsigned             words_sent    = 0;
   int unsigned             quads_made    = 0;
   int unsigned             settings_made = 0;

   quad_scoreboard          sb = new();

   grid_boundary_quad_generator_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_start_req (req_start_req),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_corner_a  (rsp_corner_a),
      .rsp_corner_b  (rsp_corner_b),
      .rsp_corner_c  (rsp_corner_c),
      .rsp_corner_d  (rsp_corner_d),
      .rsp_face_id   (rsp_face_id),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a run that hangs or crawls is a failure in its own right.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver pops at random according to the stall percentage of the phase.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   // A result word is taken at an edge where pop is high and the queue is not empty.
   // Values are read in the active region, so they are those from before the edge.
   always @(posedge clock) begin : result_monitor
      quad_word_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_corner_a, rsp_corner_b, rsp_corner_c, rsp_corner_d,
                 rsp_face_id, rsp_last};
         sb.check_word(got);
      end
   end

   // Offers one request word, with random idle cycles in front of it, and returns
   // at the edge where the block took it. Push stays high so that back-to-back
   // words need no second assignment in the same time step.
   task automatic push_word(input bit start);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_start_req <= start;
      do @(posedge clock); while (req_full);
      words_sent++;
      if (sb.note_request(start)) quads_made++;
   endtask

   // Stops sending and waits until every queued quad is out and any word that makes
   // no quad has had time to pass through the block.
   task automatic settle();
      req_push <= 1'b0;
      while (sb.quads_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // One transfer on the register port: setup cycle, then access until pready.
   task automatic csr_access(input bit is_write, input logic [1:0] reg_idx,
                             input logic [CFG_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {reg_idx, 2'b00};
      // The upper data bits are junk that the register must not keep.
      csr_pwdata  <= {(CSR_DATA_W - CFG_W)'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a node count while the block is quiet, then reads it back.
   task automatic write_count(input logic [1:0] reg_idx, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      settle();
      csr_access(1'b1, reg_idx, value, rdata);
      sb.node_count[reg_idx] = value;
      csr_access(1'b0, reg_idx, value, rdata);
      if (rdata !== CSR_DATA_W'(value))
         sb.report($sformatf("register %0d reads %0d, expected %0d", reg_idx, rdata, value));
      settings_made++;
   endtask

   // Mostly small grids so that whole sweeps fit, with planes, degenerate axes and
   // counts at or beyond the bound now and then.
   function automatic logic [CFG_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return CFG_W'(1);
      if (r < 70) return CFG_W'($urandom_range(6, 2));
      if (r < 85) return CFG_W'($urandom_range(40, 7));
      case ($urandom_range(5))
         0:       return CFG_W'(0);
         1:       return CFG_W'(1023);
         2:       return CFG_W'(1024);
         3:       return CFG_W'(1025);
         4:       return CFG_W'(2047);
         default: return CFG_W'($urandom_range(2047));
      endcase
   endfunction

   initial begin : stimulus
      logic [1:0]  reg_list [3];
      int unsigned round, n_words, base, waited;
      bit          start;
      reg_list = '{REG_NODES_X, REG_NODES_Y, REG_NODES_Z};
      round    = 0;
      waited   = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With the power-up counts of one, an advance with no sweep and
      // a start on an empty grid must both stay silent.
      push_word(1'b0);
      push_word(1'b1);

      // A small solid grid swept to its end through all six faces; the extra advance
      // after the final quad must give nothing.
      write_count(REG_NODES_X, 11'd3);
      write_count(REG_NODES_Y, 11'd2);
      write_count(REG_NODES_Z, 11'd2);
      push_word(1'b1);
      repeat (10) push_word(1'b0);

      // Counts out of range (top of the register, zero, just above the bound) give
      // a large plane; a start in the middle of it throws the sweep away.
      write_count(REG_NODES_X, 11'd2047);
      write_count(REG_NODES_Y, 11'd0);
      write_count(REG_NODES_Z, 11'd1025);
      push_word(1'b1);
      push_word(1'b0);
      push_word(1'b1);

      // A plane in z, then the grid turns solid while the plane sweep is under way:
      // the face counter then sits above the last face and must act as y-max.
      write_count(REG_NODES_X, 11'd3);
      write_count(REG_NODES_Y, 11'd3);
      write_count(REG_NODES_Z, 11'd0);
      push_word(1'b1);
      push_word(1'b0);
      write_count(REG_NODES_Z, 11'd1);
      push_word(1'b1);
      write_count(REG_NODES_Z, 11'd3);
      push_word(1'b0);

      // Deep z-max indices, then the grid turns into a plane in mid-sweep, then into
      // an empty plane, which ends the sweep without a word.
      write_count(REG_NODES_X, 11'd2);
      write_count(REG_NODES_Y, 11'd2);
      write_count(REG_NODES_Z, 11'd1024);
      push_word(1'b1);
      push_word(1'b0);
      write_count(REG_NODES_Y, 11'd1);
      push_word(1'b0);
      write_count(REG_NODES_X, 11'd1);
      push_word(1'b0);
      push_word(1'b0);

      // Random part. Each round picks an idling pattern, rewrites some counts while
      // the block is quiet and then sends mostly well-formed sweeps: a start when no
      // sweep runs, advances while one does, and the odd restart or stray advance.
      // A sweep left running at the end of a round meets the new counts.
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         case (round % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         start = 1'b0;
         for (int k = 0; k < 3; k++)
            if (($urandom_range(99) < 50) || (k == 2 && !start)) begin
               write_count(reg_list[k], pick_count());
               start = 1'b1;
            end
         n_words = $urandom_range(100, 10);
         for (int j = 0; j < n_words; j++) begin
            if (j == 0 && $urandom_range(1)) start = 1'b1;
            else if (!sb.sweep_on) start = ($urandom_range(99) < 75);
            else start = ($urandom_range(99) < 3);
            push_word(start);
         end
         round++;
      end

      // Drain: everything sent, wait for the last quads and a little beyond them so
      // that a stray extra word would still be seen.
      req_push <= 1'b0;
      while (sb.quads_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES + 4) @(posedge clock);
      if (sb.quads_due.size() != 0)
         sb.report($sformatf("%0d quads never arrived", sb.quads_due.size()));

      $display("Sent %0d request words (%0d making a quad) over %0d register writes",
               words_sent, quads_made, settings_made);
      $display("and %0d random rounds; checked %0d quads under four idling patterns.",
               round, sb.quads_checked);
      if (sb.mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
